FILE: rtl/core/ptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int OFFSET_W = 12;
    localparam int IDX_W    = 9;
    localparam int WORD_W   = 64;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_level;

    localparam t_kind KIND_MAP   = 2'd0;
    localparam t_kind KIND_UNMAP = 2'd1;
    localparam t_kind KIND_XLATE = 2'd2;
    localparam t_kind KIND_NONE  = 2'd3;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NOT_MAPPED = 2'd1;
    localparam t_status ST_NO_FRAMES  = 2'd2;

    localparam t_level LEAF_LEVEL = 2'd3;

    localparam logic [WORD_W-1:0]   PTE_PRESENT = 64'h1;
    localparam logic [OFFSET_W-1:0] PTE_LINK_LO = 12'h003;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    clr_wr;
        logic    alloc;
        logic    step;
        logic    leaf_wr;
        logic    leaf_clr;
        logic    res_set;
        logic    res_addr_en;
        t_status res_status;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic  clr_last;
        logic  present;
        logic  bad_ref;
        logic  frames_full;
        logic  leaf_level;
        logic  out_free;
        t_kind kind;
    } t_sts;

    function automatic logic [IDX_W-1:0] level_index(input logic [WORD_W-1:0] va,
                                                     input t_level lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/four_level_page_table_walker.sv
// Four-level page-table walker over a local store of TABLE_FRAMES 4 KiB table
// frames (frame 0 is the root), held in one single-port-write, registered-read
// memory. After reset the block clears all TABLE_FRAMES * 512 entries with
// in_ready low. Each request then costs one memory read (S_READ) and one
// decision (S_EVAL) per level for a map, unmap or translate; a walk may stop
// early at any level, and in_ready stays low until its result has moved to
// the output register. The table reads depend on each other and go serially
// through the one memory read port.
// A finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker #(
    parameter int TABLE_FRAMES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_virtual_address,
    input  wire logic [63:0] i_physical_address,
    input  wire logic [63:0] i_entry_flags,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_translated_address,
    output logic [1:0]       o_status
);
    import ptw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptw_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_kind               (i_kind),
        .i_virtual_address    (i_virtual_address),
        .i_physical_address   (i_physical_address),
        .i_entry_flags        (i_entry_flags),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_translated_address (o_translated_address),
        .o_status             (o_status)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ptw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ptw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ptw_pkg::t_sts i_sts,
    output ptw_pkg::t_cmd      o_cmd
);
    import ptw_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_RESP;
                if (i_sts.kind == KIND_NONE) begin
                    o_cmd.res_status = ST_OK;
                end else if (!i_sts.leaf_level) begin
                    if (i_sts.present) begin
                        if (i_sts.bad_ref) begin
                            o_cmd.res_status = ST_NOT_MAPPED;
                        end else begin
                            o_cmd.res_set = 1'b0;
                            o_cmd.step    = 1'b1;
                            n_state       = S_READ;
                        end
                    end else if (i_sts.kind == KIND_MAP) begin
                        if (i_sts.frames_full) begin
                            o_cmd.res_status = ST_NO_FRAMES;
                        end else begin
                            o_cmd.res_set = 1'b0;
                            o_cmd.alloc   = 1'b1;
                            n_state       = S_READ;
                        end
                    end else begin
                        o_cmd.res_status = ST_NOT_MAPPED;
                    end
                end else begin
                    case (i_sts.kind)
                        KIND_MAP:   o_cmd.leaf_wr  = 1'b1;
                        KIND_UNMAP: o_cmd.leaf_clr = 1'b1;
                        default: begin
                            if (i_sts.present) begin
                                o_cmd.res_addr_en = 1'b1;
                            end else begin
                                o_cmd.res_status = ST_NOT_MAPPED;
                            end
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ptw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ptw_dp #(
    parameter int TABLE_FRAMES = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ptw_pkg::t_cmd   i_cmd,
    output ptw_pkg::t_sts        o_sts,
    input  wire ptw_pkg::t_kind  i_kind,
    input  wire logic [63:0]     i_virtual_address,
    input  wire logic [63:0]     i_physical_address,
    input  wire logic [63:0]     i_entry_flags,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [63:0]          o_translated_address,
    output ptw_pkg::t_status     o_status
);
    import ptw_pkg::*;

    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NW    = $clog2(TABLE_FRAMES + 1);
    localparam int SW    = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);
    localparam int HI_W  = WORD_W - OFFSET_W;
    localparam logic [SW-1:0] CLR_LAST = SW'(DEPTH - 1);

    logic [WORD_W-1:0] mem [DEPTH];

    t_kind             r_kind;
    logic [WORD_W-1:0] r_va;
    logic [WORD_W-1:0] r_pa;
    logic [WORD_W-1:0] r_flags;
    t_level            r_level;
    logic [FW-1:0]     r_frame;
    logic [NW-1:0]     r_next_free;
    logic [SW-1:0]     r_clr_addr;
    logic [WORD_W-1:0] r_rdata;
    t_status           r_res_status;
    logic [WORD_W-1:0] r_res_addr;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_addr;

    logic [SW-1:0]     slot_addr;
    logic              wr_en;
    logic [SW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign slot_addr = {r_frame, level_index(r_va, r_level)};

    always_comb begin
        wr_en   = i_cmd.clr_wr | i_cmd.alloc | i_cmd.leaf_wr | i_cmd.leaf_clr;
        wr_addr = i_cmd.clr_wr ? r_clr_addr : slot_addr;
        wr_data = '0;
        if (i_cmd.alloc) begin
            wr_data = {HI_W'(r_next_free), PTE_LINK_LO};
        end else if (i_cmd.leaf_wr) begin
            wr_data = {r_pa[WORD_W-1:OFFSET_W], {OFFSET_W{1'b0}}} | r_flags | PTE_PRESENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[slot_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_va    <= i_virtual_address;
            r_pa    <= i_physical_address;
            r_flags <= i_entry_flags;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_addr   <= i_cmd.res_addr_en ?
                            {r_rdata[WORD_W-1:OFFSET_W], r_va[OFFSET_W-1:0]} : '0;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_frame     <= '0;
            r_next_free <= NW'(1);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + SW'(1);
            end
            if (i_cmd.load) begin
                r_level <= '0;
                r_frame <= '0;
            end else if (i_cmd.step) begin
                r_level <= r_level + t_level'(1);
                r_frame <= r_rdata[OFFSET_W +: FW];
            end else if (i_cmd.alloc) begin
                r_level     <= r_level + t_level'(1);
                r_frame     <= r_next_free[FW-1:0];
                r_next_free <= r_next_free + NW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clr_last    = (r_clr_addr == CLR_LAST);
        o_sts.present     = r_rdata[0];
        o_sts.bad_ref     = (r_rdata[WORD_W-1:OFFSET_W] >= HI_W'(TABLE_FRAMES));
        o_sts.frames_full = (r_next_free >= NW'(TABLE_FRAMES));
        o_sts.leaf_level  = (r_level == LEAF_LEVEL);
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.kind        = r_kind;
    end

    assign o_out_valid          = r_out_valid;
    assign o_translated_address = r_out_addr;
    assign o_status             = r_out_status;

endmodule

`default_nettype wire

FILE: rtl/core/ptw_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module ptw_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_kind,
    input wire logic [63:0] i_virtual_address,
    input wire logic [63:0] i_physical_address,
    input wire logic [63:0] i_entry_flags,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_translated_address,
    input wire logic [1:0]  o_status
);
    import ptw_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_translated_address))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NOT_MAPPED
            || o_status == ST_NO_FRAMES))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_translated_address == 64'd0)
        else $error("failed request carries an address");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("block ready right after reset");

endmodule

bind four_level_page_table_walker ptw_chk u_chk (.*);

`default_nettype wire
